/* rtl/core/lrufr_pkg.sv */
// lrufr_pkg: shared constants, word types and state encodings for the LRU list core.
// No dependencies; imported by lrufr_ram users and lru_frame_replacement_core.
package lrufr_pkg;

    localparam int NUM_FRAMES = 32;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

    // Fixed field widths of the request and response words
    localparam int ACTION_W = 2;
    localparam int FIDX_W   = 5;
    localparam int OCC_W    = 6;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TOUCH  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EVICT  = 2'd2;

    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [FIDX_W-1:0]   frame_index;
    } req_t;

    typedef struct packed {
        logic [FIDX_W-1:0] evicted_frame;
        logic              evict_valid;
        logic [OCC_W-1:0]  occupancy;
        logic              status;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COMMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_NOOP,
        OP_APPEND,
        OP_MOVE,
        OP_EVICT,
        OP_EMPTY
    } op_t;

endpackage

/* rtl/core/lrufr_ram.sv */
// lrufr_ram: generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lrufr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/lru_frame_replacement_core.sv */
// lru_frame_replacement_core: LRU order over page frames as a doubly linked list.
// Depends on lrufr_pkg and lrufr_ram (next and prev link memories).
// rsp_valid is registered: it rises after the word commits out of EXEC, or out of COMMIT
//   for a move or when the response slot was busy in EXEC.
// A new word is taken only in IDLE, once the last one has committed; a move (insert or
//   touch of a non-newest member) appends in COMMIT after its unlink writes in EXEC.
// A stalled response holds the core in its commit state until the slot frees.
// Reset: membership bits, list ends, count and control clear at once; link RAMs
//   are not cleared, an entry's read data is only used after it was written.
module lru_frame_replacement_core
    import lrufr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    req_t                  item_reg;
    logic [NUM_FRAMES-1:0] in_list_reg, in_list_next;
    frame_t                oldest_reg, oldest_next;
    frame_t                newest_reg, newest_next;
    cnt_t                  count_reg, count_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // Link memories: next points toward more recent, prev toward less recent
    logic   nl_we, pl_we, rd_en;
    frame_t nl_waddr, pl_waddr, nl_wdata, pl_wdata, rd_addr;
    frame_t nl_rdata, pl_rdata;

    lrufr_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_next_ram (
        .clk   (clk),
        .we    (nl_we),
        .waddr (nl_waddr),
        .wdata (nl_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (nl_rdata)
    );

    lrufr_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_prev_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (pl_rdata)
    );

    // ------------------------------------------------------------------
    // Decode of the held word
    // ------------------------------------------------------------------
    frame_t f;
    logic   f_ok;
    logic   member;
    op_t    op;
    logic   slot_free;
    logic   commit;

    assign f         = FRAME_W'(item_reg.frame_index);
    assign f_ok      = 32'(item_reg.frame_index) < 32'(NUM_FRAMES);
    assign member    = in_list_reg[f];
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        op = OP_NOOP;
        if (item_reg.action inside {ACT_INSERT, ACT_TOUCH})
        begin
            if (!f_ok)
                op = OP_NOOP;
            else if (!member)
                op = OP_APPEND;
            else if (f == newest_reg)
                op = OP_NOOP;       // already most recent
            else
                op = OP_MOVE;       // insert of a member acts as touch
        end
        else if (item_reg.action == ACT_EVICT)
        begin
            op = (count_reg == '0) ? OP_EMPTY : OP_EVICT;
        end
    end

    // A move relinks its neighbors in EXEC (not for the oldest), then appends in COMMIT;
    // everything else commits out of EXEC, or out of COMMIT if the response slot is busy.
    assign commit = slot_free &&
                    ((state_reg == ST_COMMIT) ||
                     ((state_reg == ST_EXEC) && (op != OP_MOVE)));

    // ------------------------------------------------------------------
    // Control and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        in_list_next   = in_list_reg;
        oldest_next    = oldest_reg;
        newest_next    = newest_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_ready ? 1'b0 : rsp_valid_reg;

        nl_we    = 1'b0;
        nl_waddr = newest_reg;
        nl_wdata = f;
        pl_we    = 1'b0;
        pl_waddr = f;
        pl_wdata = newest_reg;

        // Links are read once per word, at accept: the frame's own entry, or
        // the oldest frame's for evict. Reads only happen in IDLE, after the
        // previous word's writes have landed, so no forwarding is needed.
        req_ready = (state_reg == ST_IDLE);
        rd_en     = 1'b0;
        rd_addr   = (req.action == ACT_EVICT) ? oldest_reg : FRAME_W'(req.frame_index);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (op == OP_MOVE)
                begin
                    // unlink from the middle; the oldest just moves its head
                    if (f != oldest_reg)
                    begin
                        nl_we    = 1'b1;
                        nl_waddr = pl_rdata;
                        nl_wdata = nl_rdata;
                        pl_we    = 1'b1;
                        pl_waddr = nl_rdata;
                        pl_wdata = pl_rdata;
                    end
                    state_next = ST_COMMIT;
                end
                else
                begin
                    state_next = commit ? ST_IDLE : ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (commit)
        begin
            rsp_next = '0;
            case (op)
                OP_APPEND:
                begin
                    if (count_reg != '0)
                        nl_we = 1'b1;        // old newest -> f
                    pl_we = 1'b1;            // f <- old newest
                    if (count_reg == '0)
                        oldest_next = f;
                    newest_next     = f;
                    in_list_next[f] = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                end
                OP_MOVE:
                begin
                    nl_we = 1'b1;
                    pl_we = 1'b1;
                    if (f == oldest_reg)
                        oldest_next = nl_rdata;
                    newest_next = f;
                end
                OP_EVICT:
                begin
                    in_list_next[oldest_reg] = 1'b0;
                    count_next               = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        oldest_next = '0;
                        newest_next = '0;
                    end
                    else
                    begin
                        oldest_next = nl_rdata;
                    end
                    rsp_next.evicted_frame = FIDX_W'(oldest_reg);
                    rsp_next.evict_valid   = 1'b1;
                end
                OP_EMPTY:
                begin
                    rsp_next.status = 1'b1;
                end
                default:
                begin
                end
            endcase
            rsp_next.occupancy = OCC_W'(count_next);
            rsp_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_list_reg   <= '0;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_list_reg   <= in_list_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            item_reg <= req;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_matches_members: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(in_list_reg)))
        else $error("count disagrees with membership bits");

    a_ends_are_members: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (in_list_reg[oldest_reg] && in_list_reg[newest_reg]))
        else $error("list end is not a member");

    a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (oldest_reg == '0 && newest_reg == '0))
        else $error("empty list with nonzero ends");

    a_no_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!nl_we && !pl_we))
        else $error("link write outside an update");

    a_rsp_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.status && rsp_reg.evict_valid))
        else $error("eviction and empty status together");

endmodule
